/* src/smrbl_pkg.sv */
// Package with shared types and constants for the SPI master ring buffer link.
package smrbl_pkg;

    localparam int RING_DEPTH = 64;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_XFER = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ring_stat_t;

endpackage

/* src/smrbl_ring.sv */
// Byte ring buffer: slot pointers, full and empty flags, and the storage array.
module smrbl_ring #(
    parameter int DEPTH = smrbl_pkg::RING_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  smrbl_pkg::ring_ctrl_t  ctrl,
    input  logic [7:0]             push_data,
    output smrbl_pkg::ring_stat_t  stat,
    output logic [7:0]             rd_data
);
    import smrbl_pkg::*;

    localparam int SLOTS  = DEPTH - 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    logic [7:0]        mem [SLOTS];
    logic [SLOT_W-1:0] wr_reg, wr_next;
    logic [SLOT_W-1:0] rd_reg, rd_next;
    logic [SLOT_W-1:0] wr_adv, rd_adv;
    logic [7:0]        rd_data_reg;

    assign wr_adv = (wr_reg == LAST_SLOT) ? '0 : wr_reg + 1'b1;
    assign rd_adv = (rd_reg == LAST_SLOT) ? '0 : rd_reg + 1'b1;

    assign stat.full  = (wr_adv == rd_reg);
    assign stat.empty = (wr_reg == rd_reg);

    assign wr_next = ctrl.push ? wr_adv : wr_reg;
    assign rd_next = ctrl.pop  ? rd_adv : rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[wr_reg] <= push_data;
        end
        if (ctrl.pop) begin
            rd_data_reg <= mem[rd_reg];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/spi_master_ring_buffer_link_unit.sv */
// Top level: request decode, transfer phase control, result register and two rings.
// The result turns valid in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken; the result register frees as it is taken.
// Each item costs one slot compare and at most one ring access, read data registered.
// Reset (aresetn low, synchronous) empties both rings, selects the send phase and
// releases select; ring contents are not cleared.
module spi_master_ring_buffer_link_unit #(
    parameter int DEPTH = smrbl_pkg::RING_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_tx_byte,
    input  logic [7:0] s_spi_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_push_failed,
    output logic       m_rx_valid,
    output logic [7:0] m_rx_byte,
    output logic       m_spi_load,
    output logic [7:0] m_spi_tx_byte,
    output logic       m_select_level
);
    import smrbl_pkg::*;

    ring_ctrl_t tx_ctrl, rx_ctrl;
    ring_stat_t tx_stat, rx_stat;
    logic [7:0] tx_rd_data, rx_rd_data;

    logic accept;
    req_t req;
    logic reply_ok;

    logic out_valid_reg, out_valid_next;
    logic push_failed_reg, push_failed_next;
    logic rx_valid_reg, rx_valid_next;
    logic spi_load_reg, spi_load_next;
    logic tx_hit_reg, tx_hit_next;
    logic awaiting_reg, awaiting_next;
    logic select_reg, select_next;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign req     = req_t'(s_req_type);
    assign reply_ok = (s_spi_rx_byte != BYTE_ZERO) && (s_spi_rx_byte != BYTE_ONES);

    always_comb begin
        tx_ctrl          = '0;
        rx_ctrl          = '0;
        push_failed_next = 1'b0;
        rx_valid_next    = 1'b0;
        spi_load_next    = 1'b0;
        tx_hit_next      = 1'b0;
        awaiting_next    = awaiting_reg;
        select_next      = select_reg;
        case (req)
            REQ_PUSH: begin
                push_failed_next = tx_stat.full;
                tx_ctrl.push     = accept && !tx_stat.full;
            end
            REQ_POP: begin
                rx_valid_next = !rx_stat.empty;
                rx_ctrl.pop   = accept && !rx_stat.empty;
            end
            REQ_XFER: begin
                if (!awaiting_reg) begin
                    select_next   = 1'b0;
                    awaiting_next = 1'b1;
                    spi_load_next = 1'b1;
                    tx_hit_next   = !tx_stat.empty;
                    tx_ctrl.pop   = accept && !tx_stat.empty;
                end else begin
                    select_next  = 1'b1;
                    awaiting_next = 1'b0;
                    rx_ctrl.push = accept && reply_ok && !rx_stat.full;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_valid_next = accept ? 1'b1 : (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            awaiting_reg  <= 1'b0;
            select_reg    <= 1'b1;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                awaiting_reg <= awaiting_next;
                select_reg   <= select_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            push_failed_reg <= push_failed_next;
            rx_valid_reg    <= rx_valid_next;
            spi_load_reg    <= spi_load_next;
            tx_hit_reg      <= tx_hit_next;
        end
    end

    smrbl_ring #(.DEPTH(DEPTH)) u_tx_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (tx_ctrl),
        .push_data (s_tx_byte),
        .stat      (tx_stat),
        .rd_data   (tx_rd_data)
    );

    smrbl_ring #(.DEPTH(DEPTH)) u_rx_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rx_ctrl),
        .push_data (s_spi_rx_byte),
        .stat      (rx_stat),
        .rd_data   (rx_rd_data)
    );

    assign m_valid        = out_valid_reg;
    assign m_push_failed  = push_failed_reg;
    assign m_rx_valid     = rx_valid_reg;
    assign m_rx_byte      = rx_valid_reg ? rx_rd_data : BYTE_ZERO;
    assign m_spi_load     = spi_load_reg;
    assign m_spi_tx_byte  = tx_hit_reg ? tx_rd_data : BYTE_ZERO;
    assign m_select_level = select_reg;

`ifndef NO_ASSERTIONS
    a_phase_tracks_select: assert property (@(posedge aclk) disable iff (!aresetn)
        awaiting_reg == !select_reg)
        else $error("transfer phase and select level disagree");

    a_send_selects: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (req == REQ_XFER) && !awaiting_reg |=> !m_select_level && m_spi_load)
        else $error("send phase did not select slave and load shifter");

    a_full_push_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (req == REQ_PUSH) && tx_stat.full |=> m_valid && m_push_failed)
        else $error("push to full transmit ring not refused");

    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_rx_valid && m_spi_load) && !(m_push_failed && m_spi_load))
        else $error("result carries flags of more than one request");
`endif

endmodule

/* dv/spi_link_checker.sv */
// Checker for the SPI ring link: predicts each result from accepted items and compares.
module spi_link_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_tx_byte,
    input  logic [7:0] s_spi_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_push_failed,
    input  logic       m_rx_valid,
    input  logic [7:0] m_rx_byte,
    input  logic       m_spi_load,
    input  logic [7:0] m_spi_tx_byte,
    input  logic       m_select_level,
    output int         mismatch_count,
    output int         replies_pending,
    output int         replies_checked
);
    import smrbl_pkg::*;

    localparam int SLOT_W = $clog2(RING_DEPTH);

    typedef struct packed {
        logic       push_failed;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       spi_load;
        logic [7:0] spi_tx_byte;
        logic       select_level;
    } link_reply_t;

    logic [7:0]        tx_ring [RING_DEPTH];
    logic [7:0]        rx_ring [RING_DEPTH];
    logic [SLOT_W-1:0] tx_wr, tx_rd, rx_wr, rx_rd;
    logic              awaiting_reply;
    logic              select_q;
    link_reply_t       expected_replies [$];

    function automatic logic [SLOT_W-1:0] ring_next(logic [SLOT_W-1:0] s);
        return (int'(s) >= RING_DEPTH - 2) ? '0 : s + 1'b1;
    endfunction

    function automatic link_reply_t predict_reply(req_t req, logic [7:0] txb,
                                                  logic [7:0] rxb);
        link_reply_t r;
        r = '0;
        case (req)
            REQ_PUSH: begin
                if (ring_next(tx_wr) == tx_rd) begin
                    r.push_failed = 1'b1;
                end else begin
                    tx_ring[tx_wr] = txb;
                    tx_wr = ring_next(tx_wr);
                end
            end
            REQ_POP: begin
                if (rx_rd != rx_wr) begin
                    r.rx_valid = 1'b1;
                    r.rx_byte  = rx_ring[rx_rd];
                    rx_rd      = ring_next(rx_rd);
                end
            end
            REQ_XFER: begin
                if (!awaiting_reply) begin
                    select_q   = 1'b0;
                    r.spi_load = 1'b1;
                    if (tx_rd != tx_wr) begin
                        r.spi_tx_byte = tx_ring[tx_rd];
                        tx_rd = ring_next(tx_rd);
                    end
                    awaiting_reply = 1'b1;
                end else begin
                    select_q       = 1'b1;
                    awaiting_reply = 1'b0;
                    // drop bus idle patterns and replies that find the ring full
                    if (rxb != BYTE_ZERO && rxb != BYTE_ONES &&
                        ring_next(rx_wr) != rx_rd) begin
                        rx_ring[rx_wr] = rxb;
                        rx_wr = ring_next(rx_wr);
                    end
                end
            end
            default: ;
        endcase
        r.select_level = select_q;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        link_reply_t want;
        link_reply_t got;
        if (!aresetn) begin
            tx_wr = '0;
            tx_rd = '0;
            rx_wr = '0;
            rx_rd = '0;
            awaiting_reply = 1'b0;
            select_q = 1'b1;
            expected_replies.delete();
            mismatch_count = 0;
            replies_checked = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_push_failed, m_rx_valid, m_rx_byte, m_spi_load,
                        m_spi_tx_byte, m_select_level};
                if (expected_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: pf=%0b rv=%0b rx=%02h ld=%0b tx=%02h sel=%0b",
                                 got.push_failed, got.rx_valid, got.rx_byte,
                                 got.spi_load, got.spi_tx_byte, got.select_level);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.push_failed !== want.push_failed ||
                        got.rx_valid !== want.rx_valid ||
                        got.rx_byte !== want.rx_byte ||
                        got.spi_load !== want.spi_load ||
                        got.spi_tx_byte !== want.spi_tx_byte ||
                        got.select_level !== want.select_level) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch on result %0d:", replies_checked);
                            $display("  expected pf=%0b rv=%0b rx=%02h ld=%0b tx=%02h sel=%0b",
                                     want.push_failed, want.rx_valid, want.rx_byte,
                                     want.spi_load, want.spi_tx_byte, want.select_level);
                            $display("  actual   pf=%0b rv=%0b rx=%02h ld=%0b tx=%02h sel=%0b",
                                     got.push_failed, got.rx_valid, got.rx_byte,
                                     got.spi_load, got.spi_tx_byte, got.select_level);
                        end
                    end
                end
                replies_checked++;
            end
            if (s_valid && s_ready)
                expected_replies.push_back(predict_reply(req_t'(s_req_type), s_tx_byte,
                                                         s_spi_rx_byte));
        end
        replies_pending = expected_replies.size();
    end

endmodule

/* dv/spi_master_ring_buffer_link_unit_tb.sv */
// Testbench top: clock, reset, item stimulus, result stalls, watchdog and verdict.
module spi_master_ring_buffer_link_unit_tb;
    import smrbl_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int IDLE_LIMIT   = 2000;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_req_type;
    logic [7:0] s_tx_byte;
    logic [7:0] s_spi_rx_byte;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_push_failed;
    logic       m_rx_valid;
    logic [7:0] m_rx_byte;
    logic       m_spi_load;
    logic [7:0] m_spi_tx_byte;
    logic       m_select_level;

    int mismatch_count;
    int replies_pending;
    int replies_checked;

    int items_sent;
    int push_count, pop_count, xfer_count, none_count;
    int burst_left;
    int idle_cycles;

    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age = 0;

    spi_master_ring_buffer_link_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_tx_byte     (s_tx_byte),
        .s_spi_rx_byte (s_spi_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_push_failed (m_push_failed),
        .m_rx_valid    (m_rx_valid),
        .m_rx_byte     (m_rx_byte),
        .m_spi_load    (m_spi_load),
        .m_spi_tx_byte (m_spi_tx_byte),
        .m_select_level(m_select_level)
    );

    spi_link_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_tx_byte      (s_tx_byte),
        .s_spi_rx_byte  (s_spi_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_push_failed  (m_push_failed),
        .m_rx_valid     (m_rx_valid),
        .m_rx_byte      (m_rx_byte),
        .m_spi_load     (m_spi_load),
        .m_spi_tx_byte  (m_spi_tx_byte),
        .m_select_level (m_select_level),
        .mismatch_count (mismatch_count),
        .replies_pending(replies_pending),
        .replies_checked(replies_checked)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // rotate a stall pattern, pick a new one each time pattern_age wraps
    always @(negedge aclk) begin
        if (pattern_age == 47) begin
            pattern_age <= 0;
            case ($urandom_range(0, 3))
                0:       ready_pattern <= 16'hFFFF;
                1:       ready_pattern <= 16'($urandom);
                2:       ready_pattern <= 16'($urandom | $urandom);
                default: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
            endcase
        end else begin
            pattern_age   <= pattern_age + 1;
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
        end
        m_ready <= ready_pattern[0];
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick_reply();
        case ($urandom_range(0, 7))
            0:       return BYTE_ZERO;
            1:       return BYTE_ONES;
            default: return 8'($urandom);
        endcase
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance, or after an idle gap when a burst ends
    task automatic send_item(input req_t req, input logic [7:0] txb, input logic [7:0] rxb);
        s_valid       = 1'b1;
        s_req_type    = req;
        s_tx_byte     = txb;
        s_spi_rx_byte = rxb;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
        case (req)
            REQ_PUSH: push_count++;
            REQ_POP:  pop_count++;
            REQ_XFER: xfer_count++;
            default:  none_count++;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (replies_pending != 0) @(negedge aclk);
    endtask

    initial begin
        int  n;
        int  seq_len;
        bit  paused;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_req_type    = REQ_NONE;
        s_tx_byte     = 8'h00;
        s_spi_rx_byte = 8'h00;
        items_sent    = 0;
        push_count    = 0;
        pop_count     = 0;
        xfer_count    = 0;
        none_count    = 0;
        burst_left    = 8;
        paused        = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_item(REQ_POP,  8'hFF, 8'hFF);
        send_item(REQ_NONE, 8'hFF, 8'hFF);
        send_item(REQ_XFER, 8'h00, 8'h00);
        send_item(REQ_XFER, 8'h00, BYTE_ZERO);
        send_item(REQ_XFER, 8'h00, 8'h00);
        send_item(REQ_XFER, 8'h00, BYTE_ONES);
        send_item(REQ_XFER, 8'h00, 8'h00);
        send_item(REQ_XFER, 8'h00, 8'h01);
        send_item(REQ_XFER, 8'h00, 8'h00);
        send_item(REQ_XFER, 8'h00, 8'hFE);
        send_item(REQ_XFER, 8'h00, 8'h00);
        send_item(REQ_XFER, 8'h00, 8'h80);
        send_item(REQ_PUSH, 8'h00, 8'h00);
        send_item(REQ_PUSH, 8'hFF, 8'h00);
        send_item(REQ_PUSH, 8'h5A, 8'h00);
        send_item(REQ_XFER, 8'h00, 8'h00);
        send_item(REQ_XFER, 8'h00, 8'h7F);
        send_item(REQ_XFER, 8'h00, 8'h00);
        send_item(REQ_XFER, 8'h00, 8'hA5);
        repeat (6) send_item(REQ_POP, 8'h00, 8'h00);
        drain_results();

        n = 0;
        while (n < RANDOM_ITEMS) begin
            if (!paused && n >= RANDOM_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    seq_len = $urandom_range(1, 70);
                    repeat (seq_len) send_item(REQ_PUSH, 8'($urandom), 8'($urandom));
                end
                3, 4, 5: begin
                    seq_len = $urandom_range(1, 130);
                    repeat (seq_len) send_item(REQ_XFER, 8'($urandom), pick_reply());
                end
                6, 7: begin
                    seq_len = $urandom_range(1, 70);
                    repeat (seq_len) send_item(REQ_POP, 8'($urandom), 8'($urandom));
                end
                default: begin
                    seq_len = $urandom_range(1, 20);
                    repeat (seq_len)
                        send_item(req_t'($urandom_range(0, 3)), 8'($urandom), pick_reply());
                end
            endcase
            n += seq_len;
        end

        s_valid = 1'b0;
        while (replies_pending != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);

        $display("Sent %0d items: %0d pushes, %0d pops, %0d transfers, %0d unused codes.",
                 items_sent, push_count, pop_count, xfer_count, none_count);
        $display("Compared %0d results, %0d mismatched.", replies_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
